FILE: rtl/bfls_pkg.sv
package bfls_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned PosW   = 16;
  localparam int unsigned SlotOW = 16;
  localparam int unsigned LvW    = 5;
  localparam int unsigned VW     = PosW + 1;
  localparam int unsigned WideW  = 32;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpSearch = 1'b1;

  typedef struct packed {
    logic              op;
    logic [PosW-1:0]   position;
    logic [KeyW-1:0]   key;
  } item_t;

  typedef struct packed {
    logic              found;
    logic [SlotOW-1:0] found_slot;
  } result_t;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StLoad   = 3'b010,
    StSearch = 3'b100
  } state_e;

endpackage

FILE: rtl/bfls_store.sv
module bfls_store #(
  parameter int unsigned AW = 16
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [bfls_pkg::KeyW-1:0]   wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [bfls_pkg::KeyW-1:0]   rdata_o
);

  localparam int unsigned Depth = 2 ** AW;

  logic [bfls_pkg::KeyW-1:0] mem_q [Depth];
  logic [bfls_pkg::KeyW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bfls_seq.sv
module bfls_seq #(
  parameter int unsigned AW = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  output logic                        item_ready_o,
  input  bfls_pkg::item_t             item_i,
  input  logic [bfls_pkg::LvW-1:0]    levels_i,
  input  logic                        res_ready_i,
  output logic                        res_valid_o,
  output bfls_pkg::result_t           res_o,
  output logic                        mem_we_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [bfls_pkg::KeyW-1:0]   mem_wdata_o,
  output logic [AW-1:0]               mem_raddr_o,
  input  logic [bfls_pkg::KeyW-1:0]   mem_rdata_i
);

  bfls_pkg::state_e state_q, state_d;
  logic [AW-1:0]               idx_q, idx_d;
  logic [bfls_pkg::LvW-1:0]    level_q, level_d;
  logic [bfls_pkg::LvW-1:0]    tz_q, tz_d;
  logic [bfls_pkg::VW-1:0]     w_q, w_d;
  logic [bfls_pkg::KeyW-1:0]   key_q, key_d;

  logic                        accept;
  logic [bfls_pkg::VW-1:0]     v;
  logic                        oob;
  logic [bfls_pkg::LvW-1:0]    lv_m1;
  logic [bfls_pkg::LvW-1:0]    sh;
  logic [bfls_pkg::WideW-1:0]  slot_wide;
  logic                        hit;
  logic                        lt;
  logic                        last;
  logic [AW-1:0]               nidx;
  logic [bfls_pkg::WideW-1:0]  idx_wide;

  assign item_ready_o = (state_q == bfls_pkg::StIdle);
  assign accept       = item_valid_i & item_ready_o;

  assign v     = bfls_pkg::VW'(item_i.position) + bfls_pkg::VW'(1);
  assign oob   = (v >> levels_i) != '0;
  assign lv_m1 = levels_i - bfls_pkg::LvW'(1);
  assign sh    = lv_m1 - tz_q;

  assign slot_wide = (bfls_pkg::WideW'(1) << sh) | bfls_pkg::WideW'(w_q >> 1);

  assign hit  = (mem_rdata_i == key_q);
  assign lt   = $signed(mem_rdata_i) < $signed(key_q);
  assign last = ({1'b0, level_q} + 6'd1) >= {1'b0, levels_i};
  assign nidx = (idx_q << 1) | AW'(lt);
  assign idx_wide = bfls_pkg::WideW'(idx_q);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    level_d     = level_q;
    tz_d        = tz_q;
    w_d         = w_q;
    key_d       = key_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = slot_wide[AW-1:0];
    mem_wdata_o = key_q;
    mem_raddr_o = idx_q;
    res_valid_o = 1'b0;
    res_o.found      = hit;
    res_o.found_slot = hit ? idx_wide[bfls_pkg::SlotOW-1:0] : '0;
    unique case (state_q)
      bfls_pkg::StIdle: begin
        if (accept) begin
          key_d = item_i.key;
          if (item_i.op == bfls_pkg::OpSearch) begin
            idx_d       = AW'(1);
            level_d     = '0;
            mem_raddr_o = AW'(1);
            state_d     = bfls_pkg::StSearch;
          end else if (!oob) begin
            w_d     = v;
            tz_d    = '0;
            state_d = bfls_pkg::StLoad;
          end
        end
      end
      bfls_pkg::StLoad: begin
        if (!w_q[0] && (tz_q < lv_m1)) begin
          w_d  = w_q >> 1;
          tz_d = tz_q + bfls_pkg::LvW'(1);
        end else begin
          mem_we_o = 1'b1;
          state_d  = bfls_pkg::StIdle;
        end
      end
      bfls_pkg::StSearch: begin
        if (hit || last) begin
          if (res_ready_i) begin
            res_valid_o = 1'b1;
            state_d     = bfls_pkg::StIdle;
          end
        end else begin
          idx_d       = nidx;
          level_d     = level_q + bfls_pkg::LvW'(1);
          mem_raddr_o = nidx;
        end
      end
      default: begin
        state_d = bfls_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfls_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    level_q <= level_d;
    tz_q    <= tz_d;
    w_q     <= w_d;
    key_q   <= key_d;
  end

endmodule

FILE: rtl/breadth_first_layout_search.sv
// Channel   Dir  Payload
// s_axis    in   tuser = op; tdata = position, key
// m_axis    out  tuser = found; tdata = found_slot
// cfg       in   cfg_wdata_i = tree_levels, taken when cfg_we_i is high
//
// Search: after the accept, the tree is walked one level at a time (at most
// tree_levels), each step set by the compare on the registered store read port.
// Load: after the accept, the shift unit strips the trailing zeros of position+1
// before the store write. Result waits in an output register; a full one stalls the
// search at its final level. Reset is async, clears control and sets
// tree_levels to 16; the store itself is not cleared.
module breadth_first_layout_search #(
  parameter int unsigned MAX_LEVELS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [47:0]                   s_axis_tdata,  // position[15:0], key[47:16]
  input  logic                          s_axis_tuser,  // op
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // found_slot[15:0]
  output logic                          m_axis_tuser,  // found
  input  logic                          cfg_we_i,
  input  logic [bfls_pkg::LvW-1:0]      cfg_wdata_i
);

  localparam logic [bfls_pkg::LvW-1:0] MaxLv = bfls_pkg::LvW'(MAX_LEVELS);

  logic [bfls_pkg::LvW-1:0]  levels_q;
  logic [bfls_pkg::LvW-1:0]  lv_eff;
  bfls_pkg::item_t           item;
  bfls_pkg::result_t         res;
  bfls_pkg::result_t         out_q;
  logic                      res_valid;
  logic                      res_ready;
  logic                      out_valid_q;

  logic                      mem_we;
  logic [MAX_LEVELS-1:0]     mem_waddr;
  logic [MAX_LEVELS-1:0]     mem_raddr;
  logic [bfls_pkg::KeyW-1:0] mem_wdata;
  logic [bfls_pkg::KeyW-1:0] mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= bfls_pkg::LvW'(16);
    end else if (cfg_we_i) begin
      levels_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    priority if (levels_q == '0) begin
      lv_eff = bfls_pkg::LvW'(1);
    end else if (levels_q > MaxLv) begin
      lv_eff = MaxLv;
    end else begin
      lv_eff = levels_q;
    end
  end

  assign item.op       = s_axis_tuser;
  assign item.position = s_axis_tdata[15:0];
  assign item.key      = s_axis_tdata[47:16];

  assign res_ready = !out_valid_q || m_axis_tready;

  bfls_seq #(
    .AW(MAX_LEVELS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .levels_i     (lv_eff),
    .res_ready_i  (res_ready),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  bfls_store #(
    .AW(MAX_LEVELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.found_slot;
  assign m_axis_tuser  = out_q.found;

endmodule

FILE: bench/layout_search_checker.sv
module layout_search_checker #(
  parameter int unsigned MAX_LEVELS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  input  logic                     s_axis_tready,
  input  logic [47:0]              s_axis_tdata,   // position[15:0], key[47:16]
  input  logic                     s_axis_tuser,   // op
  input  logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  input  logic [15:0]              m_axis_tdata,   // found_slot[15:0]
  input  logic                     m_axis_tuser,   // found
  input  logic                     cfg_we_i,
  input  logic [bfls_pkg::LvW-1:0] cfg_wdata_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);

  localparam int unsigned Depth = (1 << MAX_LEVELS) - 1;

  logic [bfls_pkg::KeyW-1:0] slot_keys [1:Depth];
  logic [bfls_pkg::LvW-1:0]  levels_reg;
  bfls_pkg::result_t         awaited_results [$];
  int unsigned               mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic int unsigned used_levels(input logic [bfls_pkg::LvW-1:0] raw);
    int unsigned lv;
    lv = raw;
    if (lv < 1) lv = 1;
    if (lv > MAX_LEVELS) lv = MAX_LEVELS;
    return lv;
  endfunction

  // midpoint construction: trailing zeros of position+1 pick the level
  function automatic int unsigned eytzinger_slot(input int unsigned pos, input int unsigned lv);
    int unsigned v;
    int unsigned tz;
    v  = pos + 1;
    tz = 0;
    while (v[tz] == 1'b0 && tz < lv - 1) tz++;
    return (1 << (lv - 1 - tz)) + (v >> (tz + 1));
  endfunction

  function automatic bfls_pkg::result_t walk_tree(input logic [bfls_pkg::KeyW-1:0] key,
                                                  input int unsigned lv);
    bfls_pkg::result_t r;
    int unsigned       idx;
    int unsigned       count;
    r     = '0;
    idx   = 1;
    count = (1 << lv) - 1;
    while (idx <= count && !r.found) begin
      if (slot_keys[idx] == key) begin
        r.found      = 1'b1;
        r.found_slot = idx[bfls_pkg::SlotOW-1:0];
      end else if ($signed(slot_keys[idx]) < $signed(key)) begin
        idx = 2 * idx + 1;
      end else begin
        idx = 2 * idx;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch at %0t: %s, expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bfls_pkg::result_t got;
    bfls_pkg::result_t want;
    bfls_pkg::item_t   it;
    int unsigned       lv;
    if (!rst_ni) begin
      levels_reg = bfls_pkg::LvW'(16);
      awaited_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.found      = m_axis_tuser;
        got.found_slot = m_axis_tdata;
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no search outstanding", 0, got.found_slot);
        end else begin
          want = awaited_results.pop_front();
          if (got.found !== want.found)
            report_mismatch("found flag", want.found, got.found);
          if (got.found_slot !== want.found_slot)
            report_mismatch("found slot", want.found_slot, got.found_slot);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it.op       = s_axis_tuser;
        it.position = s_axis_tdata[bfls_pkg::PosW-1:0];
        it.key      = s_axis_tdata[bfls_pkg::PosW +: bfls_pkg::KeyW];
        lv          = used_levels(levels_reg);
        if (it.op == bfls_pkg::OpSearch) begin
          awaited_results.insert(awaited_results.size(), walk_tree(it.key, lv));
        end else if (it.position < (1 << lv) - 1) begin
          slot_keys[eytzinger_slot(it.position, lv)] = it.key;
        end
      end
      if (cfg_we_i) levels_reg = cfg_wdata_i;
    end
    pending_o <= awaited_results.size();
  end

endmodule

FILE: bench/tb_top.sv
module tb_top;

  localparam int unsigned MaxLevels    = 16;
  localparam int unsigned SettleCycles = 32;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned ItemTarget   = 800;
  localparam longint      CycleLimit   = 1000000;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [47:0]               s_axis_tdata  = '0;   // position[15:0], key[47:16]
  logic                      s_axis_tuser  = 1'b0; // op
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [15:0]               m_axis_tdata;         // found_slot[15:0]
  logic                      m_axis_tuser;         // found
  logic                      cfg_we_i      = 1'b0;
  logic [bfls_pkg::LvW-1:0]  cfg_wdata_i   = '0;
  int unsigned               fail_count;
  int unsigned               pending_count;

  bit                        send_gaps    = 1'b0;
  bit                        recv_stalls  = 1'b0;
  bit                        hold_request = 1'b0;
  int unsigned               stall_left   = 0;
  int unsigned               hold_left    = 0;
  longint unsigned           cycle_count  = 0;
  int unsigned               cur_levels   = 16;
  int unsigned               sent_items   = 0;
  logic [bfls_pkg::KeyW-1:0] sorted_keys [0:65534];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  breadth_first_layout_search #(
    .MAX_LEVELS(MaxLevels)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  layout_search_checker #(
    .MAX_LEVELS(MaxLevels)
  ) lookup_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = LongHold;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 17);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(input logic op, input int unsigned pos,
                           input logic [bfls_pkg::KeyW-1:0] key);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {key, pos[bfls_pkg::PosW-1:0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_items++;
  endtask

  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_levels(input logic [bfls_pkg::LvW-1:0] raw);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= raw;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_levels = (raw == '0) ? 1 : ((raw > MaxLevels) ? MaxLevels : raw);
  endtask

  // ascending keys with repeats, wide spread or tightly packed
  task automatic load_sorted_tree(input bit descending, input bit tight);
    int unsigned count;
    int unsigned p;
    longint      gap_max;
    longint      k;
    count   = (1 << cur_levels) - 1;
    gap_max = tight ? 3 : 64'hFFFF_FFFF / (count + 1);
    k = tight ? longint'($urandom_range(0, 32'hFFFC_0000)) - 64'sd2147483648
              : longint'($urandom_range(0, gap_max)) - 64'sd2147483648;
    for (p = 0; p < count; p++) begin
      sorted_keys[p] = k[bfls_pkg::KeyW-1:0];
      k += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, gap_max);
    end
    for (p = 0; p < count; p++) begin
      if (descending) send_item(bfls_pkg::OpLoad, count - 1 - p, sorted_keys[count - 1 - p]);
      else send_item(bfls_pkg::OpLoad, p, sorted_keys[p]);
    end
  endtask

  // evenly spaced ascending keys, one per sorted position
  function automatic logic [bfls_pkg::KeyW-1:0] path_key(input int unsigned pos);
    return ((pos << 16) + 32'd32768) ^ 32'h8000_0000;
  endfunction

  // loads only the slots on one root-to-leaf path, then searches along it
  task automatic probe_path(input int unsigned rounds);
    int unsigned r;
    int unsigned lev;
    int unsigned leaf;
    int unsigned node;
    int unsigned step;
    for (r = 0; r < rounds; r++) begin
      leaf = 2 * $urandom_range(0, (1 << (cur_levels - 1)) - 1);
      node = (1 << (cur_levels - 1)) - 1;
      step = 1 << (cur_levels - 1);
      for (lev = 0; lev < cur_levels; lev++) begin
        send_item(bfls_pkg::OpLoad, node, path_key(node));
        step = step >> 1;
        if (leaf < node) node = node - step;
        else node = node + step;
      end
      send_item(bfls_pkg::OpSearch, $urandom_range(0, 65535), path_key(leaf));
      send_item(bfls_pkg::OpSearch, 0, path_key(leaf) + 1);
      send_item(bfls_pkg::OpSearch, 0, path_key(leaf) - 1);
      send_item(bfls_pkg::OpSearch, 0, path_key((1 << (cur_levels - 1)) - 1));
    end
  endtask

  task automatic search_mix(input int unsigned n);
    int unsigned               count;
    int unsigned               i;
    int unsigned               p;
    logic [bfls_pkg::KeyW-1:0] key;
    count = (1 << cur_levels) - 1;
    for (i = 0; i < n; i++) begin
      p = $urandom_range(0, count - 1);
      case ($urandom_range(0, 19))
        8, 9:   key = sorted_keys[p] + 1;
        10, 11: key = sorted_keys[p] - 1;
        12, 13: key = $urandom;
        14:     key = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        default: key = sorted_keys[p];
      endcase
      case ($urandom_range(0, 19))
        0, 1: begin
          send_item(bfls_pkg::OpLoad, $urandom_range(count, 65535), $urandom);
        end
        2: begin
          sorted_keys[p] = $urandom;
          send_item(bfls_pkg::OpLoad, p, sorted_keys[p]);
        end
        default: begin
          send_item(bfls_pkg::OpSearch, $urandom_range(0, 65535), key);
        end
      endcase
    end
  endtask

  initial begin : stimulus
    logic [bfls_pkg::LvW-1:0] raw;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-level tree via a zero register value; stray positions ignored
    set_levels('0);
    send_item(bfls_pkg::OpLoad, 0, 32'h8000_0000);
    send_item(bfls_pkg::OpLoad, 65535, 32'd5);
    send_item(bfls_pkg::OpLoad, 1, 32'd7);
    send_item(bfls_pkg::OpSearch, 0, 32'h8000_0000);
    send_item(bfls_pkg::OpSearch, 65535, 32'h7FFF_FFFF);
    send_item(bfls_pkg::OpSearch, 0, 32'd0);
    drain_and_settle();

    set_levels(bfls_pkg::LvW'(2));
    send_item(bfls_pkg::OpLoad, 2, 32'h7FFF_FFFF);
    send_item(bfls_pkg::OpLoad, 0, 32'h8000_0000);
    send_item(bfls_pkg::OpLoad, 1, 32'd0);
    send_item(bfls_pkg::OpLoad, 3, 32'd9);
    send_item(bfls_pkg::OpSearch, 0, 32'h8000_0000);
    send_item(bfls_pkg::OpSearch, 0, 32'd0);
    send_item(bfls_pkg::OpSearch, 0, 32'h7FFF_FFFF);
    send_item(bfls_pkg::OpSearch, 0, 32'hFFFF_FFFF);
    send_item(bfls_pkg::OpSearch, 0, 32'd1);
    drain_and_settle();

    set_levels(bfls_pkg::LvW'(3));
    load_sorted_tree(1'b0, 1'b1);
    send_item(bfls_pkg::OpSearch, 0, sorted_keys[0]);
    send_item(bfls_pkg::OpSearch, 0, sorted_keys[6]);
    send_item(bfls_pkg::OpSearch, 0, sorted_keys[3] + 1);
    drain_and_settle();

    // full-size tree, probed one path at a time; larger register values clamp
    set_levels(bfls_pkg::LvW'(16));
    send_gaps    = 1'b0;
    recv_stalls  = 1'b1;
    hold_request = 1'b1;
    probe_path(3);
    send_gaps    = 1'b1;
    probe_path(3);
    drain_and_settle();
    set_levels(bfls_pkg::LvW'(31));
    probe_path(2);
    drain_and_settle();
    set_levels(bfls_pkg::LvW'(17));
    probe_path(2);
    drain_and_settle();

    while (sent_items < ItemTarget - 100) begin
      case ($urandom_range(0, 9))
        0:       raw = '0;
        1:       raw = bfls_pkg::LvW'($urandom_range(17, 31));
        2:       raw = bfls_pkg::LvW'(16);
        default: raw = bfls_pkg::LvW'($urandom_range(1, 6));
      endcase
      set_levels(raw);
      send_gaps   = $urandom_range(0, 3) != 0;
      recv_stalls = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 7) == 0) hold_request = 1'b1;
      if (cur_levels <= 6) begin
        load_sorted_tree($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
        search_mix($urandom_range(20, 60));
      end else begin
        probe_path($urandom_range(1, 3));
      end
      drain_and_settle();
    end

    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    while (hold_left != 0 || stall_left != 0) @(posedge clk_i);
    set_levels(bfls_pkg::LvW'(5));
    load_sorted_tree(1'b0, 1'b1);
    search_mix(40);
    drain_and_settle();

    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
